// File: hw/rtl/rprop_pkg.sv
`timescale 1ns / 1ps

package rprop_pkg;

  localparam int IDX_W   = 4;
  localparam int STEP_W  = 31;
  localparam int WORD_W  = 32;
  localparam int FAC_W   = 16;
  localparam int FRAC_W  = 14;
  localparam int SUM_W   = 64;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 31;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 104;

  localparam logic [WORD_W-1:0] LIK_RESET = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [CFG_A_W-1:0] {
    CFG_INIT_STEP = 3'd0,
    CFG_MIN_STEP  = 3'd1,
    CFG_MAX_STEP  = 3'd2,
    CFG_SHRINK    = 3'd3,
    CFG_GROW      = 3'd4,
    CFG_STOP_THR  = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_GRAD = 1'b1
  } action_t;

  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [WORD_W-1:0] grad;
    logic [WORD_W-1:0] param;
    logic [WORD_W-1:0] best;
  } entry_t;

endpackage

// File: hw/rtl/rprop_step_size_update_core.sv
`timescale 1ns / 1ps

// Rprop step unit, one parameter element per transfer. A load transfer (tuser 0) sets a
// parameter's start value and resets its step; a gradient transfer (tuser 1) adapts the step
// by the grow or shrink factor, moves the parameter against the gradient sign, tracks the best
// parameters on likelihood improvement, and on tlast reports convergence of the gradient norm.
// The block takes one transfer every cycle unless the output is stalled. The per-parameter
// state memory is read into the update stage when a transfer is accepted and written back as the
// result enters the output register; a bypass register covers back-to-back updates of one index.
// Configuration must be written while the block is idle.
module rprop_step_size_update_core
  import rprop_pkg::*;
#(
  parameter int MAX_PARAMS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_A_W-1:0]    cfg_addr,
  input  logic [CFG_D_W-1:0]    cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // index[3:0], value[35:4], likelihood[67:36]
  input  logic                  in_tuser,   // action
  input  logic                  in_tlast,   // last_element
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_index, new_param, new_step, best_param,
                                            // converged
  output logic                  out_tlast   // last_out
);

  localparam int AW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int EXT_W = AW + IDX_W;

  logic [STEP_W-1:0]  init_step_r, min_step_r, max_step_r, stop_thr_r;
  logic [FAC_W-1:0]   shrink_r, grow_r;
  logic [2*STEP_W-1:0] thr_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_step_r <= STEP_W'(1677722);
      min_step_r  <= STEP_W'(17);
      max_step_r  <= STEP_W'(838860800);
      shrink_r    <= FAC_W'(8192);
      grow_r      <= FAC_W'(19661);
      stop_thr_r  <= '0;
      thr_sq_r    <= '0;
    end else begin
      thr_sq_r <= (2*STEP_W)'(stop_thr_r) * (2*STEP_W)'(stop_thr_r);
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          CFG_INIT_STEP: init_step_r <= cfg_wdata;
          CFG_MIN_STEP:  min_step_r  <= cfg_wdata;
          CFG_MAX_STEP:  max_step_r  <= cfg_wdata;
          CFG_SHRINK:    shrink_r    <= cfg_wdata[FAC_W-1:0];
          CFG_GROW:      grow_r      <= cfg_wdata[FAC_W-1:0];
          CFG_STOP_THR:  stop_thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  logic in_fire;
  logic s1_valid_r, s1_go, s1_fire;
  logic [IDX_W-1:0]  s1_idx_r;
  logic [WORD_W-1:0] s1_val_r, s1_lik_r;
  logic              s1_act_r, s1_last_r;
  entry_t            rd_r;

  logic [EXT_W-1:0] in_ext, s1_ext;
  logic [AW-1:0]    in_addr, s1_addr;

  assign in_ext  = EXT_W'(in_tdata[IDX_W-1:0]);
  assign in_addr = in_ext[AW-1:0];
  assign s1_ext  = EXT_W'(s1_idx_r);
  assign s1_addr = s1_ext[AW-1:0];

  logic out_valid_r;
  assign s1_go     = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_tready = !s1_valid_r || s1_go;
  assign in_fire   = in_tvalid && in_tready;

  entry_t mem [MAX_PARAMS];
  entry_t wr_entry;
  logic   s1_ok;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r <= mem[in_addr];
    end
    if (s1_fire && s1_ok) begin
      mem[s1_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r  <= in_tdata[IDX_W-1:0];
      s1_val_r  <= in_tdata[IDX_W+WORD_W-1:IDX_W];
      s1_lik_r  <= in_tdata[IDX_W+2*WORD_W-1:IDX_W+WORD_W];
      s1_act_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  logic          byp_valid_r;
  logic [AW-1:0] byp_addr_r;
  entry_t        byp_entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (s1_fire && s1_ok) begin
      byp_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ok) begin
      byp_addr_r  <= s1_addr;
      byp_entry_r <= wr_entry;
    end
  end

  logic [WORD_W-1:0] best_lik_r;
  logic              improved_r;
  logic [SUM_W-1:0]  sq_sum_r;

  entry_t cur;
  logic   better, improved_nxt;
  logic   pg_pos, pg_neg, sign_same, sign_diff;
  logic   g_pos, g_neg;
  logic [FAC_W-1:0]          factor;
  logic [STEP_W+FAC_W-1:0]   step_prod;
  logic [STEP_W+FAC_W-FRAC_W-1:0] scaled;
  logic [STEP_W-1:0]         step_nxt;
  logic signed [WORD_W+1:0]  p_ext;
  logic [WORD_W-1:0]         param_nxt, stored, mag;
  logic [SUM_W-1:0]          sq;
  logic [SUM_W:0]            sum_ext;
  logic [SUM_W-1:0]          sum_upd;

  assign cur = (byp_valid_r && byp_addr_r == s1_addr) ? byp_entry_r : rd_r;
  assign s1_ok = s1_ext < EXT_W'(MAX_PARAMS);

  assign better = (s1_idx_r == '0) && ($signed(s1_lik_r) > $signed(best_lik_r));
  assign improved_nxt = improved_r || better;

  assign g_pos     = !s1_val_r[WORD_W-1] && (s1_val_r != '0);
  assign g_neg     = s1_val_r[WORD_W-1];
  assign pg_pos    = !cur.grad[WORD_W-1] && (cur.grad != '0);
  assign pg_neg    = cur.grad[WORD_W-1];
  assign sign_same = (g_pos && pg_pos) || (g_neg && pg_neg);
  assign sign_diff = (g_pos && pg_neg) || (g_neg && pg_pos);

  assign factor    = sign_same ? grow_r : shrink_r;
  assign step_prod = (STEP_W+FAC_W)'(cur.step) * (STEP_W+FAC_W)'(factor);
  assign scaled    = step_prod[STEP_W+FAC_W-1:FRAC_W];

  always_comb begin
    if (sign_same) begin
      if (scaled > (STEP_W+FAC_W-FRAC_W)'(max_step_r)) begin
        step_nxt = max_step_r;
      end else begin
        step_nxt = scaled[STEP_W-1:0];
      end
    end else begin
      priority if (scaled < (STEP_W+FAC_W-FRAC_W)'(min_step_r)) begin
        step_nxt = min_step_r;
      end else if (|scaled[STEP_W+FAC_W-FRAC_W-1:STEP_W]) begin
        step_nxt = '1;
      end else begin
        step_nxt = scaled[STEP_W-1:0];
      end
    end
  end

  always_comb begin
    if (g_pos) begin
      p_ext = $signed((WORD_W+2)'($signed(cur.param))) - $signed((WORD_W+2)'(step_nxt));
    end else if (g_neg) begin
      p_ext = $signed((WORD_W+2)'($signed(cur.param))) + $signed((WORD_W+2)'(step_nxt));
    end else begin
      p_ext = $signed((WORD_W+2)'($signed(cur.param)));
    end
    if (p_ext[WORD_W+1:WORD_W-1] == 3'b000 || p_ext[WORD_W+1:WORD_W-1] == 3'b111) begin
      param_nxt = p_ext[WORD_W-1:0];
    end else if (p_ext[WORD_W+1]) begin
      param_nxt = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      param_nxt = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  assign stored  = sign_diff ? '0 : s1_val_r;
  assign mag     = stored[WORD_W-1] ? (~stored + 1'b1) : stored;
  assign sq      = SUM_W'(mag) * SUM_W'(mag);
  assign sum_ext = {1'b0, sq_sum_r} + {1'b0, sq};
  assign sum_upd = (s1_ok ? (sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0]) : sq_sum_r);

  logic [IDX_W-1:0]  o_idx;
  logic [WORD_W-1:0] o_param, o_best;
  logic [STEP_W-1:0] o_step;
  logic              o_conv;

  always_comb begin
    wr_entry = cur;
    o_idx    = s1_idx_r;
    o_param  = '0;
    o_step   = '0;
    o_best   = '0;
    o_conv   = 1'b0;
    if (s1_act_r == ACT_LOAD) begin
      wr_entry.param = s1_val_r;
      wr_entry.best  = s1_val_r;
      wr_entry.step  = init_step_r;
      wr_entry.grad  = '0;
    end else begin
      wr_entry.param = param_nxt;
      wr_entry.step  = step_nxt;
      wr_entry.grad  = stored;
      if (improved_nxt) begin
        wr_entry.best = cur.param;
      end
      if (s1_last_r) begin
        o_conv = sum_upd < SUM_W'(thr_sq_r);
      end
    end
    if (s1_ok) begin
      o_param = wr_entry.param;
      o_step  = wr_entry.step;
      o_best  = wr_entry.best;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_lik_r <= LIK_RESET;
      improved_r <= 1'b0;
      sq_sum_r   <= '0;
    end else if (s1_fire) begin
      if (s1_act_r == ACT_LOAD) begin
        best_lik_r <= LIK_RESET;
      end else begin
        if (better) begin
          best_lik_r <= s1_lik_r;
        end
        if (s1_last_r) begin
          sq_sum_r   <= '0;
          improved_r <= 1'b0;
        end else begin
          sq_sum_r   <= sum_upd;
          improved_r <= improved_nxt;
        end
      end
    end
  end

  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= OUT_DATA_W'({o_conv, o_best, o_step, o_param, o_idx});
      out_last_r <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("output became valid without an item in the update stage");

  a_conv_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[OUT_DATA_W-5]) |-> out_tlast)
    else $error("convergence flagged on an item that does not end the round");

  a_load_resets_lik: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_act_r == ACT_LOAD) |=> (best_lik_r == LIK_RESET))
    else $error("best likelihood not reset by a load transfer");

  a_round_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_act_r == ACT_GRAD && s1_last_r) |=> (sq_sum_r == '0 && !improved_r))
    else $error("round state not cleared after the last element");
`endif

endmodule
